/* rtl/core/tcs_pkg.sv */
// Shared types and constants for the turn confirmation sequencer.
// Phase, status and opcode encodings, counter indexes and limit defaults.
// No dependencies.
package tcs_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntN  = 8;
  localparam int unsigned CntSelW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [DataW-1:0] TurnLimitRst    = 32'd10000;
  localparam logic [DataW-1:0] ConfirmLimitRst = 32'd5000;

  localparam logic [CfgIdxW-1:0] CFG_TURN_LIMIT    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM_LIMIT = 1'd1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_GEN     = 3'd1,
    PH_PRES    = 3'd2,
    PH_PEND    = 3'd3,
    PH_CONF    = 3'd4,
    PH_ABORT   = 3'd5,
    PH_TIMEOUT = 3'd6,
    PH_CLEAR   = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ARG     = 3'd1,
    ST_STATE   = 3'd2,
    ST_GEN     = 3'd3,
    ST_SESSION = 3'd4,
    ST_CONFIRM = 3'd5,
    ST_TIMEOUT = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    OP_BEGIN   = 3'd0,
    OP_PRESENT = 3'd1,
    OP_CONFIRM = 3'd2,
    OP_DENY    = 3'd3,
    OP_ABORT   = 3'd4,
    OP_TICK    = 3'd5,
    OP_FORGET  = 3'd6,
    OP_READ    = 3'd7
  } opcode_e;

  localparam logic [CntSelW-1:0] CNT_STARTED     = 3'd0;
  localparam logic [CntSelW-1:0] CNT_GENFAIL     = 3'd1;
  localparam logic [CntSelW-1:0] CNT_PRESENTED   = 3'd2;
  localparam logic [CntSelW-1:0] CNT_CONFIRMED   = 3'd3;
  localparam logic [CntSelW-1:0] CNT_DENIED      = 3'd4;
  localparam logic [CntSelW-1:0] CNT_INTERRUPTED = 3'd5;
  localparam logic [CntSelW-1:0] CNT_TIMEDOUT    = 3'd6;
  localparam logic [CntSelW-1:0] CNT_CLEARS      = 3'd7;

endpackage

/* rtl/core/turn_confirmation_sequencer_top.sv */
// Turn confirmation sequencer top level: request register, event decode,
// turn state, event counters and result register. Depends on tcs_pkg.
//
// Each request is registered, then updates the turn state when the result
// register can take it. One request is taken every clock while the output
// is not stalled, and its result passes from the request register to the
// result register. The rate is set by the state update (phase, payload and
// one counter bump). Configuration writes are always ready and take effect
// on the next cycle.
module turn_confirmation_sequencer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  opcode_i,
  input  logic [tcs_pkg::DataW-1:0]   session_id_i,
  input  logic [tcs_pkg::DataW-1:0]   now_ms_i,
  input  logic [1:0]                  candidate_class_i,
  input  logic                        derive_ok_i,
  input  logic                        confirm_needed_i,
  input  logic                        abstain_flag_i,
  input  logic [tcs_pkg::CntSelW-1:0] counter_select_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [2:0]                  phase_now_o,
  output logic [tcs_pkg::DataW-1:0]   counter_value_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tcs_pkg::DataW-1:0]   cfg_data_i
);

  localparam int unsigned W = tcs_pkg::DataW;

  // request register
  logic                        req_valid_q;
  tcs_pkg::opcode_e            op_q;
  logic [W-1:0]                sid_q;
  logic [W-1:0]                now_q;
  logic [1:0]                  cls_q;
  logic                        dok_q;
  logic                        cneed_q;
  logic                        abst_q;
  logic [tcs_pkg::CntSelW-1:0] sel_q;

  // turn state
  tcs_pkg::phase_e phase_q, phase_d;
  logic [W-1:0]    owner_q, owner_d;
  logic [W-1:0]    start_q, start_d;
  logic [W-1:0]    pres_q, pres_d;
  logic            nconf_q, nconf_d;
  logic            abstd_q, abstd_d;
  logic [W-1:0]    cnt_q [tcs_pkg::CntN];

  logic [W-1:0] turn_limit_q;
  logic [W-1:0] confirm_limit_q;

  // result register
  logic                 out_valid_q;
  tcs_pkg::status_e     out_status_q;
  tcs_pkg::phase_e      out_phase_q;
  logic [W-1:0]         out_cnt_q;

  logic                        proc_en;
  logic                        accept;
  tcs_pkg::status_e            st;
  logic [W-1:0]                cval;
  logic                        bump_en;
  logic [tcs_pkg::CntSelW-1:0] bump_sel;
  logic [W-1:0]                elapsed;
  logic [W-1:0]                limit;
  logic                        sid_zero;

  assign proc_en     = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = req_valid_q && !proc_en;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign phase_now_o     = out_phase_q;
  assign counter_value_o = out_cnt_q;

  assign sid_zero = (sid_q == '0);
  assign elapsed  = now_q - ((phase_q == tcs_pkg::PH_PEND) ? pres_q : start_q);
  assign limit    = (phase_q == tcs_pkg::PH_PEND) ? confirm_limit_q : turn_limit_q;

  always_comb begin
    phase_d  = phase_q;
    owner_d  = owner_q;
    start_d  = start_q;
    pres_d   = pres_q;
    nconf_d  = nconf_q;
    abstd_d  = abstd_q;
    st       = tcs_pkg::ST_OK;
    cval     = '0;
    bump_en  = 1'b0;
    bump_sel = tcs_pkg::CNT_STARTED;
    case (op_q)
      tcs_pkg::OP_BEGIN: begin
        if (sid_zero) begin
          st = tcs_pkg::ST_ARG;
        end else if (phase_q != tcs_pkg::PH_IDLE && phase_q != tcs_pkg::PH_ABORT &&
                     phase_q != tcs_pkg::PH_TIMEOUT && phase_q != tcs_pkg::PH_CLEAR) begin
          st = tcs_pkg::ST_STATE;
        end else begin
          phase_d  = tcs_pkg::PH_GEN;
          owner_d  = sid_q;
          start_d  = now_q;
          pres_d   = '0;
          nconf_d  = 1'b0;
          abstd_d  = 1'b0;
          bump_en  = 1'b1;
          bump_sel = tcs_pkg::CNT_STARTED;
        end
      end
      tcs_pkg::OP_PRESENT: begin
        if (phase_q != tcs_pkg::PH_GEN) begin
          st = tcs_pkg::ST_STATE;
        end else if (cls_q == 2'd3 || !dok_q) begin
          phase_d  = tcs_pkg::PH_ABORT;
          owner_d  = '0;
          start_d  = '0;
          pres_d   = '0;
          nconf_d  = 1'b0;
          abstd_d  = 1'b0;
          bump_en  = 1'b1;
          bump_sel = tcs_pkg::CNT_GENFAIL;
          st       = tcs_pkg::ST_GEN;
        end else begin
          pres_d   = now_q;
          nconf_d  = cneed_q;
          abstd_d  = abst_q;
          bump_en  = 1'b1;
          bump_sel = tcs_pkg::CNT_PRESENTED;
          phase_d  = cneed_q ? tcs_pkg::PH_PEND : tcs_pkg::PH_PRES;
        end
      end
      tcs_pkg::OP_CONFIRM, tcs_pkg::OP_DENY: begin
        if (sid_zero) begin
          st = tcs_pkg::ST_ARG;
        end else if (phase_q != tcs_pkg::PH_PEND) begin
          st = tcs_pkg::ST_STATE;
        end else if (sid_q != owner_q) begin
          st = tcs_pkg::ST_SESSION;
        end else if (op_q == tcs_pkg::OP_CONFIRM) begin
          if (abstd_q || !nconf_q) begin
            st = tcs_pkg::ST_CONFIRM;
          end else begin
            phase_d  = tcs_pkg::PH_CONF;
            owner_d  = '0;
            bump_en  = 1'b1;
            bump_sel = tcs_pkg::CNT_CONFIRMED;
          end
        end else begin
          phase_d  = tcs_pkg::PH_ABORT;
          owner_d  = '0;
          start_d  = '0;
          pres_d   = '0;
          nconf_d  = 1'b0;
          abstd_d  = 1'b0;
          bump_en  = 1'b1;
          bump_sel = tcs_pkg::CNT_DENIED;
        end
      end
      tcs_pkg::OP_ABORT: begin
        if (phase_q == tcs_pkg::PH_IDLE || phase_q == tcs_pkg::PH_CLEAR) begin
          st = tcs_pkg::ST_STATE;
        end else begin
          phase_d  = tcs_pkg::PH_ABORT;
          owner_d  = '0;
          start_d  = '0;
          pres_d   = '0;
          nconf_d  = 1'b0;
          abstd_d  = 1'b0;
          bump_en  = 1'b1;
          bump_sel = tcs_pkg::CNT_INTERRUPTED;
        end
      end
      tcs_pkg::OP_TICK: begin
        if ((phase_q == tcs_pkg::PH_GEN || phase_q == tcs_pkg::PH_PRES ||
             phase_q == tcs_pkg::PH_PEND) && (elapsed >= limit)) begin
          phase_d  = tcs_pkg::PH_TIMEOUT;
          owner_d  = '0;
          start_d  = '0;
          pres_d   = '0;
          nconf_d  = 1'b0;
          abstd_d  = 1'b0;
          bump_en  = 1'b1;
          bump_sel = tcs_pkg::CNT_TIMEDOUT;
          st       = tcs_pkg::ST_TIMEOUT;
        end
      end
      tcs_pkg::OP_FORGET: begin
        phase_d  = tcs_pkg::PH_CLEAR;
        owner_d  = '0;
        start_d  = '0;
        pres_d   = '0;
        nconf_d  = 1'b0;
        abstd_d  = 1'b0;
        bump_en  = 1'b1;
        bump_sel = tcs_pkg::CNT_CLEARS;
      end
      tcs_pkg::OP_READ: begin
        cval = cnt_q[sel_q];
      end
      default: begin
        st = tcs_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (accept) begin
      req_valid_q <= 1'b1;
    end else if (proc_en) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= tcs_pkg::opcode_e'(opcode_i);
      sid_q   <= session_id_i;
      now_q   <= now_ms_i;
      cls_q   <= candidate_class_i;
      dok_q   <= derive_ok_i;
      cneed_q <= confirm_needed_i;
      abst_q  <= abstain_flag_i;
      sel_q   <= counter_select_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tcs_pkg::PH_IDLE;
      owner_q <= '0;
      start_q <= '0;
      pres_q  <= '0;
      nconf_q <= 1'b0;
      abstd_q <= 1'b0;
    end else if (proc_en) begin
      phase_q <= phase_d;
      owner_q <= owner_d;
      start_q <= start_d;
      pres_q  <= pres_d;
      nconf_q <= nconf_d;
      abstd_q <= abstd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tcs_pkg::CntN; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (proc_en && bump_en) begin
      cnt_q[bump_sel] <= cnt_q[bump_sel] + W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_limit_q    <= tcs_pkg::TurnLimitRst;
      confirm_limit_q <= tcs_pkg::ConfirmLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tcs_pkg::CFG_TURN_LIMIT) begin
        turn_limit_q <= cfg_data_i;
      end
      if (cfg_index_i == tcs_pkg::CFG_CONFIRM_LIMIT) begin
        confirm_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en) begin
      out_status_q <= st;
      out_phase_q  <= phase_d;
      out_cnt_q    <= cval;
    end
  end

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_valid_q)
    else $error("input stalled with empty request register");

  a_cnt_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && counter_value_o != '0) |-> status_o == tcs_pkg::ST_OK)
    else $error("counter value returned with non-ok status");

  a_timeout_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == tcs_pkg::ST_TIMEOUT) |-> phase_now_o == tcs_pkg::PH_TIMEOUT)
    else $error("timeout status without timed out phase");

  a_conf_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tcs_pkg::PH_CONF) |-> owner_q == '0)
    else $error("owner session kept after confirmation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(phase_now_o) &&
                                      $stable(status_o) && $stable(counter_value_o)))
    else $error("stalled result changed");
`endif

endmodule

/* tb/turn_confirmation_sequencer_top_test.sv */
// Self-checking testbench for turn_confirmation_sequencer_top.
// A scoreboard class predicts each event result; tasks drive requests
// and register writes. Depends on tcs_pkg and the top level RTL.
`timescale 1ns / 1ps

module turn_confirmation_sequencer_top_test;

  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned SettleCycles   = 6;
  localparam int unsigned RandomPerPhase = 125;
  localparam int unsigned PhaseCount     = 4;

  typedef struct packed {
    tcs_pkg::opcode_e            opcode;
    logic [tcs_pkg::DataW-1:0]   session_id;
    logic [tcs_pkg::DataW-1:0]   now_ms;
    logic [1:0]                  candidate_class;
    logic                        derive_ok;
    logic                        confirm_needed;
    logic                        abstain_flag;
    logic [tcs_pkg::CntSelW-1:0] counter_select;
  } turn_req_t;

  typedef struct packed {
    tcs_pkg::status_e          status;
    tcs_pkg::phase_e           phase;
    logic [tcs_pkg::DataW-1:0] counter_value;
  } turn_rsp_t;

  class turn_scoreboard;
    tcs_pkg::phase_e           turn_phase;
    logic [tcs_pkg::DataW-1:0] owner;
    logic [tcs_pkg::DataW-1:0] start_ms;
    logic [tcs_pkg::DataW-1:0] present_ms;
    logic                      needs_confirm;
    logic                      abstained;
    logic [tcs_pkg::DataW-1:0] event_cnt [tcs_pkg::CntN];
    logic [tcs_pkg::DataW-1:0] turn_limit;
    logic [tcs_pkg::DataW-1:0] confirm_limit;
    turn_rsp_t                 predicted_results[$];
    int unsigned               errors;

    function new();
      turn_limit    = tcs_pkg::TurnLimitRst;
      confirm_limit = tcs_pkg::ConfirmLimitRst;
      turn_phase    = tcs_pkg::PH_IDLE;
      zero_payload();
      foreach (event_cnt[i]) event_cnt[i] = '0;
      errors = 0;
    endfunction

    function void zero_payload();
      owner         = '0;
      start_ms      = '0;
      present_ms    = '0;
      needs_confirm = 1'b0;
      abstained     = 1'b0;
    endfunction

    function void bump(logic [tcs_pkg::CntSelW-1:0] idx);
      event_cnt[idx] = event_cnt[idx] + 1'b1;
    endfunction

    function void set_limit(logic [tcs_pkg::CfgIdxW-1:0] idx,
                            logic [tcs_pkg::DataW-1:0] value);
      if (idx == tcs_pkg::CFG_TURN_LIMIT) turn_limit = value;
      else confirm_limit = value;
    endfunction

    function turn_rsp_t advance_turn(turn_req_t r);
      turn_rsp_t                 rsp;
      logic [tcs_pkg::DataW-1:0] elapsed;
      logic [tcs_pkg::DataW-1:0] limit;
      rsp.status        = tcs_pkg::ST_OK;
      rsp.counter_value = '0;
      case (r.opcode)
        tcs_pkg::OP_BEGIN: begin
          if (r.session_id == '0) begin
            rsp.status = tcs_pkg::ST_ARG;
          end else if (turn_phase != tcs_pkg::PH_IDLE && turn_phase != tcs_pkg::PH_ABORT &&
                       turn_phase != tcs_pkg::PH_TIMEOUT &&
                       turn_phase != tcs_pkg::PH_CLEAR) begin
            rsp.status = tcs_pkg::ST_STATE;
          end else begin
            zero_payload();
            turn_phase = tcs_pkg::PH_GEN;
            owner      = r.session_id;
            start_ms   = r.now_ms;
            bump(tcs_pkg::CNT_STARTED);
          end
        end
        tcs_pkg::OP_PRESENT: begin
          if (turn_phase != tcs_pkg::PH_GEN) begin
            rsp.status = tcs_pkg::ST_STATE;
          end else if (r.candidate_class == 2'd3 || !r.derive_ok) begin
            zero_payload();
            turn_phase = tcs_pkg::PH_ABORT;
            bump(tcs_pkg::CNT_GENFAIL);
            rsp.status = tcs_pkg::ST_GEN;
          end else begin
            present_ms    = r.now_ms;
            needs_confirm = r.confirm_needed;
            abstained     = r.abstain_flag;
            bump(tcs_pkg::CNT_PRESENTED);
            turn_phase = r.confirm_needed ? tcs_pkg::PH_PEND : tcs_pkg::PH_PRES;
          end
        end
        tcs_pkg::OP_CONFIRM, tcs_pkg::OP_DENY: begin
          if (r.session_id == '0) begin
            rsp.status = tcs_pkg::ST_ARG;
          end else if (turn_phase != tcs_pkg::PH_PEND) begin
            rsp.status = tcs_pkg::ST_STATE;
          end else if (r.session_id != owner) begin
            rsp.status = tcs_pkg::ST_SESSION;
          end else if (r.opcode == tcs_pkg::OP_CONFIRM) begin
            if (abstained || !needs_confirm) begin
              rsp.status = tcs_pkg::ST_CONFIRM;
            end else begin
              turn_phase = tcs_pkg::PH_CONF;
              owner      = '0;
              bump(tcs_pkg::CNT_CONFIRMED);
            end
          end else begin
            zero_payload();
            turn_phase = tcs_pkg::PH_ABORT;
            bump(tcs_pkg::CNT_DENIED);
          end
        end
        tcs_pkg::OP_ABORT: begin
          if (turn_phase == tcs_pkg::PH_IDLE || turn_phase == tcs_pkg::PH_CLEAR) begin
            rsp.status = tcs_pkg::ST_STATE;
          end else begin
            zero_payload();
            turn_phase = tcs_pkg::PH_ABORT;
            bump(tcs_pkg::CNT_INTERRUPTED);
          end
        end
        tcs_pkg::OP_TICK: begin
          if (turn_phase == tcs_pkg::PH_GEN || turn_phase == tcs_pkg::PH_PRES ||
              turn_phase == tcs_pkg::PH_PEND) begin
            if (turn_phase == tcs_pkg::PH_PEND) begin
              elapsed = r.now_ms - present_ms;
              limit   = confirm_limit;
            end else begin
              elapsed = r.now_ms - start_ms;
              limit   = turn_limit;
            end
            if (elapsed >= limit) begin
              zero_payload();
              turn_phase = tcs_pkg::PH_TIMEOUT;
              bump(tcs_pkg::CNT_TIMEDOUT);
              rsp.status = tcs_pkg::ST_TIMEOUT;
            end
          end
        end
        tcs_pkg::OP_FORGET: begin
          zero_payload();
          turn_phase = tcs_pkg::PH_CLEAR;
          bump(tcs_pkg::CNT_CLEARS);
        end
        default: begin
          rsp.counter_value = event_cnt[r.counter_select];
        end
      endcase
      rsp.phase = turn_phase;
      return rsp;
    endfunction

    function void note_request(turn_req_t r);
      predicted_results.push_back(advance_turn(r));
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(logic [2:0] status, logic [2:0] phase_now,
                      logic [tcs_pkg::DataW-1:0] value);
      turn_rsp_t exp;
      if (predicted_results.size() == 0) begin
        report("result with no request pending");
        return;
      end
      exp = predicted_results.pop_front();
      if (status !== exp.status)
        report($sformatf("status %0d, expected %0d", status, exp.status));
      if (phase_now !== exp.phase)
        report($sformatf("phase %0d, expected %0d", phase_now, exp.phase));
      if (value !== exp.counter_value)
        report($sformatf("counter 0x%08h, expected 0x%08h", value, exp.counter_value));
    endtask
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  turn_req_t                   drv         = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [2:0]                  status_o;
  logic [2:0]                  phase_now_o;
  logic [tcs_pkg::DataW-1:0]   counter_value_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [tcs_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [tcs_pkg::DataW-1:0]   cfg_data_i  = '0;

  turn_scoreboard sb;
  int unsigned    in_idle_pct;
  int unsigned    out_stall_pct;
  int unsigned    items_sent;
  int unsigned    quiet_cycles;

  turn_confirmation_sequencer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (drv.opcode),
    .session_id_i      (drv.session_id),
    .now_ms_i          (drv.now_ms),
    .candidate_class_i (drv.candidate_class),
    .derive_ok_i       (drv.derive_ok),
    .confirm_needed_i  (drv.confirm_needed),
    .abstain_flag_i    (drv.abstain_flag),
    .counter_select_i  (drv.counter_select),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .phase_now_o       (phase_now_o),
    .counter_value_o   (counter_value_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(status_o, phase_now_o, counter_value_o);
      if (in_valid_i && !in_stall_o) sb.note_request(drv);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic turn_req_t rand_req();
    turn_req_t r;
    r.opcode          = tcs_pkg::opcode_e'($urandom_range(0, 7));
    r.session_id      = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
    r.now_ms          = $urandom;
    r.candidate_class = 2'($urandom_range(0, 3));
    r.derive_ok       = 1'($urandom_range(0, 1));
    r.confirm_needed  = 1'($urandom_range(0, 1));
    r.abstain_flag    = 1'($urandom_range(0, 1));
    r.counter_select  = 3'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic logic [tcs_pkg::DataW-1:0] pick_elapsed(
      logic [tcs_pkg::DataW-1:0] limit);
    case ($urandom_range(0, 5))
      0:       return limit - 1'b1;
      1:       return limit;
      2:       return limit + 1'b1;
      3:       return $urandom_range(0, 50);
      4:       return $urandom;
      default: return limit >> 1;
    endcase
  endfunction

  task automatic send_request(input turn_req_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    drv        <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
  endtask

  task automatic send_op(input tcs_pkg::opcode_e op, input logic [tcs_pkg::DataW-1:0] sid,
                         input logic [tcs_pkg::DataW-1:0] now, input logic [1:0] cls,
                         input logic dok, input logic cneed, input logic abst,
                         input logic [tcs_pkg::CntSelW-1:0] sel);
    turn_req_t r;
    r = '{op, sid, now, cls, dok, cneed, abst, sel};
    send_request(r);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [tcs_pkg::CfgIdxW-1:0] idx,
                              input logic [tcs_pkg::DataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_limit(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    send_op(tcs_pkg::OP_READ,    32'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, tcs_pkg::CNT_CLEARS);
    send_op(tcs_pkg::OP_BEGIN,   32'd0, 32'd0, 2'd0, 1'b1, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_PRESENT, 32'd0, 32'd0, 2'd0, 1'b1, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_CONFIRM, 32'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_ABORT,   32'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_TICK,    32'd0, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'hFFFF_FFFF, 32'hFFFF_FFF0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'd9, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_TICK,    32'd0, 32'hFFFF_FFF0 + 32'd9999, 2'd0, 1'b0, 1'b0, 1'b0,
            3'd0);
    send_op(tcs_pkg::OP_PRESENT, 32'd0, 32'd0, 2'd3, 1'b1, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'd1, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_PRESENT, 32'd0, 32'd100, 2'd2, 1'b1, 1'b1, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_CONFIRM, 32'd2, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_TICK,    32'd0, 32'd5099, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_TICK,    32'd0, 32'd5100, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_ABORT,   32'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'd4, 32'd20, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_PRESENT, 32'd0, 32'd30, 2'd1, 1'b1, 1'b1, 1'b1, 3'd0);
    send_op(tcs_pkg::OP_CONFIRM, 32'd4, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_DENY,    32'd4, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'd6, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_PRESENT, 32'd0, 32'd5, 2'd0, 1'b0, 1'b1, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'd7, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_PRESENT, 32'd0, 32'd5, 2'd0, 1'b1, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_CONFIRM, 32'd7, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_TICK,    32'd0, 32'd10000, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'd8, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_PRESENT, 32'd0, 32'd1, 2'd0, 1'b1, 1'b1, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_CONFIRM, 32'd8, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_BEGIN,   32'd9, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_FORGET,  32'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_ABORT,   32'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_op(tcs_pkg::OP_READ,    32'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0, tcs_pkg::CNT_STARTED);
  endtask

  // one well-formed turn with random content, then a random ending
  task automatic run_turn();
    turn_req_t                 r;
    logic [tcs_pkg::DataW-1:0] sid;
    logic [tcs_pkg::DataW-1:0] t0;
    logic [tcs_pkg::DataW-1:0] t1;
    logic                      pend;
    sid = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
    if (sid == '0) sid = 32'd1;
    t0 = $urandom;
    r = rand_req();
    r.opcode     = tcs_pkg::OP_BEGIN;
    r.session_id = sid;
    r.now_ms     = t0;
    send_request(r);
    if ($urandom_range(0, 3) == 0) begin
      r = rand_req();
      r.opcode = tcs_pkg::OP_TICK;
      r.now_ms = t0 + pick_elapsed(sb.turn_limit);
      send_request(r);
    end
    r = rand_req();
    r.opcode          = tcs_pkg::OP_PRESENT;
    r.candidate_class = ($urandom_range(0, 6) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r.derive_ok       = ($urandom_range(0, 9) != 0);
    r.confirm_needed  = ($urandom_range(0, 9) < 7);
    r.abstain_flag    = ($urandom_range(0, 4) == 0);
    t1 = t0 + $urandom_range(0, 3000);
    r.now_ms = t1;
    pend = r.confirm_needed;
    send_request(r);
    r = rand_req();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        r.opcode     = ($urandom_range(0, 2) == 0) ? tcs_pkg::OP_DENY : tcs_pkg::OP_CONFIRM;
        r.session_id = ($urandom_range(0, 5) == 0) ? $urandom : sid;
      end
      6: begin
        r.opcode = tcs_pkg::OP_TICK;
        r.now_ms = pend ? t1 + pick_elapsed(sb.confirm_limit)
                        : t0 + pick_elapsed(sb.turn_limit);
      end
      7: r.opcode = tcs_pkg::OP_ABORT;
      8: r.opcode = tcs_pkg::OP_FORGET;
      default: begin
        r.opcode     = tcs_pkg::OP_BEGIN;
        r.session_id = sid;
      end
    endcase
    send_request(r);
    if ($urandom_range(0, 2) == 0) begin
      r = rand_req();
      r.opcode = tcs_pkg::OP_READ;
      send_request(r);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned halfway;
    bit          paused;
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 84;
          out_stall_pct = 0;
          write_config(tcs_pkg::CFG_TURN_LIMIT, 32'd0);
          write_config(tcs_pkg::CFG_CONFIRM_LIMIT, 32'hFFFF_FFFF);
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 84;
          write_config(tcs_pkg::CFG_TURN_LIMIT, 32'hFFFF_FFFF);
          write_config(tcs_pkg::CFG_CONFIRM_LIMIT, 32'd0);
        end
        default: begin
          in_idle_pct   = 9;
          out_stall_pct = 9;
          write_config(tcs_pkg::CFG_TURN_LIMIT, $urandom_range(1, 20000));
          write_config(tcs_pkg::CFG_CONFIRM_LIMIT, $urandom_range(1, 10000));
        end
      endcase
      if (ph == 0) run_directed();
      target  = items_sent + RandomPerPhase;
      halfway = items_sent + RandomPerPhase / 2;
      paused  = 1'b0;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) != 0) begin
          run_turn();
        end else begin
          send_request(rand_req());
        end
        if (!paused && items_sent >= halfway) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
